FILE: design/sgr_pkg.sv
`default_nettype none
package sgr_pkg;

  localparam int unsigned GLYPH_SIZE  = 8;
  localparam int unsigned COL_W       = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [3:0]  MAX_SCALE = 4'd8;
  localparam logic [7:0]  LETTER_L  = 8'h6C;
  localparam logic [2:0]  FIX_ROW   = 3'd6;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SCALE  = 3'd0,
    REG_STRIDE = 3'd1,
    REG_DEPTH  = 3'd2,
    REG_FG     = 3'd3,
    REG_BG     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic [2:0] row_index;
    logic [7:0] row_bits;
    logic [9:0] origin_x;
    logic [9:0] origin_y;
  } in_req_t;

  typedef struct packed {
    logic [20:0] pixel_index;
    logic [3:0]  run_length;
    logic [31:0] pixel_color;
    logic        last_run;
  } out_req_t;

  typedef struct packed {
    logic [3:0]  scale_factor;
    logic [10:0] line_stride;
    logic        pixel_depth;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
  } cfg_t;

  // One classified row: bit c of a mask is glyph column c (column 0 leftmost)
  typedef struct packed {
    logic [GLYPH_SIZE-1:0] fg_cols;
    logic [GLYPH_SIZE-1:0] col_mask;
    logic [20:0]           base;
    logic [3:0]            scale;
  } job_t;

  function automatic logic [3:0] eff_scale(input logic [3:0] sf);
    logic [3:0] s;
    s = sf;
    if (sf == 4'd0) s = 4'd1;
    else if (sf > MAX_SCALE) s = MAX_SCALE;
    return s;
  endfunction

  // Lowest set column of a mask
  function automatic logic [COL_W-1:0] first_col(input logic [GLYPH_SIZE-1:0] m);
    logic [COL_W-1:0] c;
    c = '0;
    for (int i = GLYPH_SIZE - 1; i >= 0; i--) begin
      if (m[i]) c = COL_W'(i);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: design/scaled_glyph_row_rasterizer_core.sv
`default_nettype none
// Scaled glyph row rasterizer.
// Input channel (in_valid_i / in_stall_o / in_data_i): one request is one glyph row
// with its character code, row number and cell origin. Output channel
// (out_valid_o / out_stall_i / out_data_o): one request is one horizontal run
// (start pixel index, length, color); last_run marks the final run of a row.
// Config channel (cfg_valid_i / cfg_ready_o): always ready; write only while idle.
// Path: input register, row queue, run generator, registered output.
// Throughput: the run generator emits one run per cycle while the output is not stalled;
// a row gives scale x (drawn columns) runs, up to 64 at scale 8; a row with nothing to
// draw (transparent background, empty bits) is dropped and emits nothing.
// The input stage and a small row queue keep taking rows while runs drain.
// Reset restores the register defaults (scale 1, stride 320, 16-bit depth,
// white foreground, background 0xFF) and empties all stages.
// A stalled output holds its run; the generator waits, then the queue fills
// and finally in_stall_o rises.
module scaled_glyph_row_rasterizer_core #(
  parameter int unsigned QUEUE_DEPTH = sgr_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sgr_pkg::in_req_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output sgr_pkg::out_req_t      out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [31:0]       cfg_data_i
);

  sgr_pkg::cfg_t cfg_q;
  sgr_pkg::job_t push_job, pop_job;
  logic          push, full, pop, job_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_factor <= 4'd1;
      cfg_q.line_stride  <= 11'd320;
      cfg_q.pixel_depth  <= 1'b0;
      cfg_q.fg_color     <= 32'hFFFF_FFFF;
      cfg_q.bg_color     <= 32'h0000_00FF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (sgr_pkg::cfg_reg_e'(cfg_index_i))
        sgr_pkg::REG_SCALE:  cfg_q.scale_factor <= cfg_data_i[3:0];
        sgr_pkg::REG_STRIDE: cfg_q.line_stride  <= cfg_data_i[10:0];
        sgr_pkg::REG_DEPTH:  cfg_q.pixel_depth  <= cfg_data_i[0];
        sgr_pkg::REG_FG:     cfg_q.fg_color     <= cfg_data_i;
        sgr_pkg::REG_BG:     cfg_q.bg_color     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sgr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_job_o (push_job),
    .full_i     (full)
  );

  sgr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (job_valid),
    .pop_job_o  (pop_job)
  );

  sgr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

FILE: design/sgr_front.sv
`default_nettype none
module sgr_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sgr_pkg::cfg_t    cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire sgr_pkg::in_req_t in_data_i,
  output logic                  push_o,
  output sgr_pkg::job_t         push_job_o,
  input  wire logic             full_i
);

  localparam int unsigned G = sgr_pkg::GLYPH_SIZE;

  logic                  a_valid_q, a_valid_d;
  logic [G-1:0]          a_fg_q;
  logic [G-1:0]          a_mask_q;
  logic [9:0]            a_ox_q;
  logic [10:0]           a_y0_q;
  logic [3:0]            a_scale_q;

  logic                  accept;
  logic [3:0]            s;
  logic [7:0]            bits;
  logic [G-1:0]          fg_cols;
  logic                  trans;
  logic [21:0]           prod;

  assign s = sgr_pkg::eff_scale(cfg_i.scale_factor);

  always_comb begin
    bits = in_data_i.row_bits;
    if (in_data_i.char_code == sgr_pkg::LETTER_L && in_data_i.row_index == sgr_pkg::FIX_ROW)
      bits[sgr_pkg::FIX_ROW] = 1'b0;
    // flip so that column 0 (the MSB) is bit 0
    for (int c = 0; c < G; c++) begin
      fg_cols[c] = bits[G-1-c];
    end
  end

  assign trans = cfg_i.pixel_depth ? (cfg_i.bg_color[7:0] == 8'd0) : !cfg_i.bg_color[0];

  assign push_o     = a_valid_q && !full_i;
  assign in_stall_o = a_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) a_valid_d = 1'b1;
    else if (push_o) a_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_fg_q    <= fg_cols;
      a_mask_q  <= fg_cols | {G{!trans}};
      a_ox_q    <= in_data_i.origin_x;
      a_y0_q    <= 11'(in_data_i.origin_y) + 11'(s) * 11'(in_data_i.row_index);
      a_scale_q <= s;
    end
  end

  assign prod = a_y0_q * cfg_i.line_stride;

  always_comb begin
    push_job_o.fg_cols  = a_fg_q;
    push_job_o.col_mask = a_mask_q;
    push_job_o.base     = prod[20:0] + 21'(a_ox_q);
    push_job_o.scale    = a_scale_q;
  end

endmodule
`default_nettype wire

FILE: design/sgr_queue.sv
`default_nettype none
module sgr_queue #(
  parameter int unsigned DEPTH = sgr_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sgr_pkg::job_t push_job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output sgr_pkg::job_t      pop_job_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sgr_pkg::job_t      mem [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o    = (cnt_q == CNT_W'(DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign pop_job_o = mem[rd_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= inc(wr_q);
      if (do_pop) rd_q <= inc(rd_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem[wr_q] <= push_job_i;
  end

endmodule
`default_nettype wire

FILE: design/sgr_back.sv
`default_nettype none
module sgr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sgr_pkg::cfg_t cfg_i,
  input  wire logic          job_valid_i,
  input  wire sgr_pkg::job_t job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output sgr_pkg::out_req_t  out_data_o
);

  localparam int unsigned G = sgr_pkg::GLYPH_SIZE;
  localparam int unsigned CW = sgr_pkg::COL_W;

  logic              busy_q, busy_d;
  logic [G-1:0]      mask_q, mask_d;
  logic [G-1:0]      fg_q, fg_d;
  logic [20:0]       base_q, base_d;
  logic [3:0]        scale_q, scale_d;
  logic [CW-1:0]     col_q, col_d;
  logic [2:0]        v_q, v_d;
  logic [20:0]       idx_q, idx_d;
  logic              oval_q, oval_d;
  sgr_pkg::out_req_t out_q, out_d;

  logic              advance, last_v, last, done, load;
  logic [G-1:0]      mask_rem;
  logic [CW-1:0]     nc, lc;
  logic [31:0]       fg_c, bg_c;

  assign fg_c = cfg_i.pixel_depth ? cfg_i.fg_color : {16'd0, cfg_i.fg_color[15:0]};
  assign bg_c = cfg_i.pixel_depth ? cfg_i.bg_color : {16'd0, cfg_i.bg_color[15:0]};

  assign advance  = busy_q && (!oval_q || !out_stall_i);
  assign last_v   = ({1'b0, v_q} == scale_q - 4'd1);
  assign mask_rem = mask_q & ~(G'(1) << col_q);
  assign last     = last_v && (mask_rem == '0);
  assign done     = advance && last;
  assign load     = job_valid_i && (!busy_q || done);
  assign pop_o    = load;
  assign nc       = sgr_pkg::first_col(mask_rem);
  assign lc       = sgr_pkg::first_col(job_i.col_mask);

  always_comb begin
    busy_d  = busy_q;
    mask_d  = mask_q;
    fg_d    = fg_q;
    base_d  = base_q;
    scale_d = scale_q;
    col_d   = col_q;
    v_d     = v_q;
    idx_d   = idx_q;
    if (advance) begin
      if (last) begin
        busy_d = 1'b0;
      end else if (last_v) begin
        // next emitted column, first line
        mask_d = mask_rem;
        col_d  = nc;
        v_d    = 3'd0;
        idx_d  = base_q + 21'(scale_q) * 21'(nc);
      end else begin
        v_d   = v_q + 3'd1;
        idx_d = idx_q + 21'(cfg_i.line_stride);
      end
    end
    if (load) begin
      // a row with nothing to draw just drops out
      busy_d  = (job_i.col_mask != '0);
      mask_d  = job_i.col_mask;
      fg_d    = job_i.fg_cols;
      base_d  = job_i.base;
      scale_d = job_i.scale;
      col_d   = lc;
      v_d     = 3'd0;
      idx_d   = job_i.base + 21'(job_i.scale) * 21'(lc);
    end
  end

  always_comb begin
    oval_d = oval_q && out_stall_i;
    out_d  = out_q;
    if (advance) begin
      oval_d            = 1'b1;
      out_d.pixel_index = idx_q;
      out_d.run_length  = scale_q;
      out_d.pixel_color = fg_q[col_q] ? fg_c : bg_c;
      out_d.last_run    = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q  <= mask_d;
    fg_q    <= fg_d;
    base_q  <= base_d;
    scale_q <= scale_d;
    col_q   <= col_d;
    v_q     <= v_d;
    idx_q   <= idx_d;
    out_q   <= out_d;
  end

  assign out_valid_o = oval_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
